// ===== src/directional_movement_index_defines.svh =====
// Assertion macros shared by the directional movement index RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef DIRECTIONAL_MOVEMENT_INDEX_DEFINES_SVH
`define DIRECTIONAL_MOVEMENT_INDEX_DEFINES_SVH

// same-cycle implication
`define DMI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmi assertion failed");

// next-cycle implication
`define DMI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmi assertion failed");

`endif

// ===== src/dmi_pkg.sv =====
// Shared types and constants of the directional movement index.
// No dependencies.
package dmi_pkg;

  localparam int PRICE_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int PERIOD_BITS_DEF = 10;
  localparam int INT_BITS        = 7;   // integer bits of a Q value (0..100)
  localparam int BARS_W          = 32;
  localparam int PERIOD_RESET    = 14;

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic sdiv_go;
    logic upd;
    logic pct_di_go;
    logic di_take;
    logic pct_dx_go;
    logic adx_step;
    logic adiv_go;
    logic adx_fin;
    logic result;
  } dmi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic seed;
    logic form;
    logic need_div;
    logic div_busy;
    logic pct_busy;
  } dmi_sts_t;

endpackage

// ===== src/dmi_pct.sv =====
// Percentage ratio unit: floor(num * 100 * 2^FRAC / den), one quotient bit a cycle.
// Saturates at 100 when num >= den, gives 0 when den is 0. Uses dmi_pkg.
module dmi_pct #(
  parameter int NUM_W     = 58,
  parameter int FRAC_BITS = dmi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [NUM_W-1:0]                     num,
  input  logic [NUM_W-1:0]                     den,
  output logic                                 busy,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] q
);
  import dmi_pkg::*;

  localparam int Q_W   = FRAC_BITS + INT_BITS;
  localparam int R_W   = NUM_W + 2;
  localparam int IDX_W = $clog2(Q_W);
  localparam logic [Q_W-1:0] HUNDRED_Q = Q_W'(100) << FRAC_BITS;

  logic [R_W-1:0]   r, r_next, t;
  logic [NUM_W-1:0] num_r, den_r;
  logic [Q_W-1:0]   q_next;
  logic [IDX_W-1:0] idx;
  logic [R_W-1:0]   den_x, den_x2;

  // one step: shift remainder, add num on a set bit of the constant, reduce
  always_comb begin
    den_x  = R_W'(den_r);
    den_x2 = R_W'({den_r, 1'b0});
    t      = {r[R_W-2:0], 1'b0} + (HUNDRED_Q[idx] ? R_W'(num_r) : '0);
    if (t >= den_x2) begin
      r_next = t - den_x2;
      q_next = {q[Q_W-2:0], 1'b0} + Q_W'(2);
    end else if (t >= den_x) begin
      r_next = t - den_x;
      q_next = {q[Q_W-2:0], 1'b1};
    end else begin
      r_next = t;
      q_next = {q[Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      num_r <= num;
      den_r <= den;
      r     <= '0;
      idx   <= IDX_W'(Q_W - 1);
      if (den == '0) begin
        q    <= '0;
        busy <= 1'b0;
      end else if (num >= den) begin
        q    <= HUNDRED_Q;
        busy <= 1'b0;
      end else begin
        q    <= '0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      r <= r_next;
      q <= q_next;
      if (idx == '0) begin
        busy <= 1'b0;
      end else begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

endmodule

// ===== src/dmi_datapath.sv =====
// Datapath of the directional movement index: series state, DM/TR, Wilder sums,
// a three-lane divider by the period, two ratio units and result registers. Uses dmi_pkg.
module dmi_datapath #(
  parameter int PRICE_BITS  = dmi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS   = dmi_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_BITS = dmi_pkg::PERIOD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [PERIOD_BITS-1:0]                 cfg_wr_data,
  input  logic [PRICE_BITS-1:0]                  bar_high,
  input  logic [PRICE_BITS-1:0]                  bar_low,
  input  logic [PRICE_BITS-1:0]                  bar_close,
  input  logic                                   series_start,
  input  dmi_pkg::dmi_cmd_t                      cmd,
  output dmi_pkg::dmi_sts_t                      sts,
  output logic [dmi_pkg::STATUS_W-1:0]           status,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] adx_value,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] plus_di,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] neg_di,
  output logic [dmi_pkg::BARS_W-1:0]             bars_seen,
  output logic [PERIOD_BITS:0]                   warmup_left
);
  import dmi_pkg::*;

  localparam int Q_W    = FRAC_BITS + INT_BITS;
  localparam int SUM_W  = PRICE_BITS + FRAC_BITS + PERIOD_BITS;
  localparam int ACC_W  = Q_W + PERIOD_BITS + 1;
  localparam int DXC_W  = PERIOD_BITS + 1;
  localparam int PROD_W = ACC_W + PERIOD_BITS;
  localparam int DIV_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int LANES  = 3;
  localparam logic [Q_W-1:0]    HUNDRED_Q = Q_W'(100) << FRAC_BITS;
  localparam logic [BARS_W-1:0] BARS_MAX  = '1;

  // configuration and per-bar latched inputs
  logic [PERIOD_BITS-1:0] period_cfg, p_cur;
  logic [PRICE_BITS-1:0]  in_high, in_low, in_close;
  logic [PRICE_BITS-1:0]  last_high, last_low, last_close;
  logic [BARS_W-1:0]      bar_counter, count_base;
  logic                   invalid_seen, zero_price;

  // per-bar movement values
  logic [PRICE_BITS-1:0]  pdm_r, mdm_r, tr_r, pdm_c, mdm_c, tr_c;
  logic signed [PRICE_BITS:0] up, down, hl, hpc, lpc, hpc_a, lpc_a, tr_s;

  // smoothed state
  logic [SUM_W-1:0]  plus_dm_sum, minus_dm_sum, range_sum;
  logic [SUM_W-1:0]  pdm_q, mdm_q, tr_q;
  logic [DXC_W-1:0]  dx_counter;
  logic [ACC_W-1:0]  adx_accumulator, acc_plus_dx;
  logic [PROD_W-1:0] adx_num;
  logic [Q_W-1:0]    pdi, mdi, di_diff, q0, q1, adx_clamp;
  logic [Q_W:0]      di_total;
  logic              pct0_busy, pct1_busy;

  // divider lanes
  logic [DIV_W-1:0]       div_dvd [LANES];
  logic [DIV_W-1:0]       div_dvd_next [LANES];
  logic [PERIOD_BITS-1:0] div_rem [LANES];
  logic [PERIOD_BITS-1:0] div_rem_next [LANES];
  logic [PERIOD_BITS:0]   div_t [LANES];
  logic [CNT_W-1:0]       div_cnt;
  logic                   div_busy;

  // bar count flags
  logic [DXC_W-1:0]  p_plus1, dxc_plus1, warm_bars;
  logic              dx_seed;

  // next result values
  logic [STATUS_W-1:0]    status_next;
  logic [Q_W-1:0]         adx_value_next, plus_di_next, neg_di_next;
  logic [BARS_W-1:0]      bars_seen_next;
  logic [PERIOD_BITS:0]   warmup_left_next;

  assign p_plus1   = {1'b0, p_cur} + DXC_W'(1);
  assign warm_bars = {p_cur, 1'b1};
  assign dxc_plus1 = dx_counter + DXC_W'(1);
  assign dx_seed   = dx_counter < {1'b0, p_cur};

  assign sts.active   = (p_cur != '0) && (bar_counter >= BARS_W'(2));
  assign sts.seed     = bar_counter <= BARS_W'(p_plus1);
  assign sts.form     = bar_counter >= BARS_W'(p_plus1);
  assign sts.need_div = !dx_seed || (dxc_plus1 == {1'b0, p_cur});
  assign sts.div_busy = div_busy;
  assign sts.pct_busy = pct0_busy || pct1_busy;

  assign zero_price = (bar_high == '0) || (bar_low == '0) || (bar_close == '0);
  assign count_base = series_start ? '0 : bar_counter;

  // directional movement and true range against the previous bar
  always_comb begin
    up    = $signed({1'b0, in_high}) - $signed({1'b0, last_high});
    down  = $signed({1'b0, last_low}) - $signed({1'b0, in_low});
    hl    = $signed({1'b0, in_high}) - $signed({1'b0, in_low});
    hpc   = $signed({1'b0, in_high}) - $signed({1'b0, last_close});
    lpc   = $signed({1'b0, in_low}) - $signed({1'b0, last_close});
    hpc_a = hpc[PRICE_BITS] ? -hpc : hpc;
    lpc_a = lpc[PRICE_BITS] ? -lpc : lpc;
    tr_s  = hl;
    if (hpc_a > tr_s) tr_s = hpc_a;
    if (lpc_a > tr_s) tr_s = lpc_a;
    pdm_c = ((up > down) && (up > 0)) ? up[PRICE_BITS-1:0] : '0;
    mdm_c = ((down > up) && (down > 0)) ? down[PRICE_BITS-1:0] : '0;
    tr_c  = tr_s[PRICE_BITS-1:0];
  end

  assign pdm_q = SUM_W'({pdm_r, {FRAC_BITS{1'b0}}});
  assign mdm_q = SUM_W'({mdm_r, {FRAC_BITS{1'b0}}});
  assign tr_q  = SUM_W'({tr_r, {FRAC_BITS{1'b0}}});

  // restoring division by the period, one bit per lane a cycle
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      div_t[i] = {div_rem[i], div_dvd[i][DIV_W-1]};
      if (div_t[i] >= {1'b0, p_cur}) begin
        div_rem_next[i] = PERIOD_BITS'(div_t[i] - {1'b0, p_cur});
        div_dvd_next[i] = {div_dvd[i][DIV_W-2:0], 1'b1};
      end else begin
        div_rem_next[i] = div_t[i][PERIOD_BITS-1:0];
        div_dvd_next[i] = {div_dvd[i][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.sdiv_go || cmd.adiv_go) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
      for (int i = 0; i < LANES; i++) div_rem[i] <= '0;
      if (cmd.sdiv_go) begin
        div_dvd[0] <= DIV_W'(plus_dm_sum);
        div_dvd[1] <= DIV_W'(minus_dm_sum);
        div_dvd[2] <= DIV_W'(range_sum);
      end else begin
        for (int i = 0; i < LANES; i++) div_dvd[i] <= DIV_W'(adx_num);
      end
    end else if (div_busy) begin
      for (int i = 0; i < LANES; i++) begin
        div_dvd[i] <= div_dvd_next[i];
        div_rem[i] <= div_rem_next[i];
      end
      if (div_cnt == CNT_W'(DIV_W - 1)) begin
        div_busy <= 1'b0;
      end else begin
        div_cnt <= div_cnt + CNT_W'(1);
      end
    end
  end

  // plus directional indicator and DX share ratio unit 0; minus indicator uses unit 1
  assign di_diff  = (pdi > mdi) ? pdi - mdi : mdi - pdi;
  assign di_total = {1'b0, pdi} + {1'b0, mdi};

  dmi_pct #(.NUM_W(SUM_W), .FRAC_BITS(FRAC_BITS)) u_pct0 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.pct_di_go || cmd.pct_dx_go),
    .num   (cmd.pct_di_go ? plus_dm_sum : SUM_W'(di_diff)),
    .den   (cmd.pct_di_go ? range_sum : SUM_W'(di_total)),
    .busy  (pct0_busy),
    .q     (q0)
  );

  dmi_pct #(.NUM_W(SUM_W), .FRAC_BITS(FRAC_BITS)) u_pct1 (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.pct_di_go),
    .num   (minus_dm_sum),
    .den   (range_sum),
    .busy  (pct1_busy),
    .q     (q1)
  );

  assign acc_plus_dx = adx_accumulator + ACC_W'(q0);
  assign adx_clamp   = (adx_accumulator > ACC_W'(HUNDRED_Q)) ? HUNDRED_Q
                                                             : adx_accumulator[Q_W-1:0];

  // series state
  always_ff @(posedge clk) begin
    if (rst) begin
      period_cfg      <= PERIOD_BITS'(PERIOD_RESET);
      last_high       <= '0;
      last_low        <= '0;
      last_close      <= '0;
      bar_counter     <= '0;
      plus_dm_sum     <= '0;
      minus_dm_sum    <= '0;
      range_sum       <= '0;
      dx_counter      <= '0;
      adx_accumulator <= '0;
      invalid_seen    <= 1'b0;
    end else begin
      if (cfg_wr_en) period_cfg <= cfg_wr_data;

      // transaction taken: latch bar, apply series restart, count
      if (cmd.load) begin
        p_cur    <= period_cfg;
        in_high  <= bar_high;
        in_low   <= bar_low;
        in_close <= bar_close;
        pdi      <= '0;
        mdi      <= '0;
        if (series_start) begin
          last_high       <= '0;
          last_low        <= '0;
          last_close      <= '0;
          plus_dm_sum     <= '0;
          minus_dm_sum    <= '0;
          range_sum       <= '0;
          dx_counter      <= '0;
          adx_accumulator <= '0;
        end
        invalid_seen <= (invalid_seen && !series_start) || zero_price;
        bar_counter  <= (count_base == BARS_MAX) ? count_base : count_base + BARS_W'(1);
      end

      if (cmd.calc) begin
        pdm_r      <= pdm_c;
        mdm_r      <= mdm_c;
        tr_r       <= tr_c;
        last_high  <= in_high;
        last_low   <= in_low;
        last_close <= in_close;
      end

      // seed sums or Wilder recurrence
      if (cmd.upd) begin
        if (sts.seed) begin
          plus_dm_sum  <= plus_dm_sum + pdm_q;
          minus_dm_sum <= minus_dm_sum + mdm_q;
          range_sum    <= range_sum + tr_q;
        end else begin
          plus_dm_sum  <= plus_dm_sum - SUM_W'(div_dvd[0]) + pdm_q;
          minus_dm_sum <= minus_dm_sum - SUM_W'(div_dvd[1]) + mdm_q;
          range_sum    <= range_sum - SUM_W'(div_dvd[2]) + tr_q;
        end
      end

      if (cmd.di_take) begin
        pdi <= q0;
        mdi <= q1;
      end

      // ADX seed accumulation or smoothing numerator
      if (cmd.adx_step) begin
        if (dx_seed) begin
          adx_accumulator <= acc_plus_dx;
          dx_counter      <= dxc_plus1;
          adx_num         <= PROD_W'(acc_plus_dx);
        end else begin
          adx_num <= PROD_W'(adx_accumulator) * PROD_W'(p_cur - PERIOD_BITS'(1))
                     + PROD_W'(q0);
        end
      end

      if (cmd.adx_fin) adx_accumulator <= ACC_W'(div_dvd[0]);
    end
  end

  // result selection
  always_comb begin
    status_next      = STATUS_OK;
    adx_value_next   = '0;
    plus_di_next     = '0;
    neg_di_next      = '0;
    bars_seen_next   = '0;
    warmup_left_next = '0;
    if (p_cur == '0) begin
      status_next = STATUS_INVALID;
    end else if (bar_counter < BARS_W'(warm_bars)) begin
      status_next      = STATUS_SHORT;
      bars_seen_next   = bar_counter;
      warmup_left_next = warm_bars - bar_counter[DXC_W-1:0];
    end else if (invalid_seen) begin
      status_next = STATUS_INVALID;
    end else begin
      adx_value_next = adx_clamp;
      plus_di_next   = pdi;
      neg_di_next    = mdi;
      bars_seen_next = bar_counter;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      status      <= status_next;
      adx_value   <= adx_value_next;
      plus_di     <= plus_di_next;
      neg_di      <= neg_di_next;
      bars_seen   <= bars_seen_next;
      warmup_left <= warmup_left_next;
    end
  end

endmodule

// ===== src/dmi_ctrl.sv =====
// Controller of the directional movement index: sequences one bar through the datapath
// and owns the handshakes. Uses dmi_pkg and directional_movement_index_defines.svh.
`include "directional_movement_index_defines.svh"

module dmi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dmi_pkg::dmi_sts_t sts,
  output dmi_pkg::dmi_cmd_t cmd
);
  import dmi_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CALC      = 4'd1;
  localparam logic [3:0] S_SDIV_GO   = 4'd2;
  localparam logic [3:0] S_SDIV_WAIT = 4'd3;
  localparam logic [3:0] S_UPD       = 4'd4;
  localparam logic [3:0] S_DI_GO     = 4'd5;
  localparam logic [3:0] S_DI_WAIT   = 4'd6;
  localparam logic [3:0] S_DX_GO     = 4'd7;
  localparam logic [3:0] S_DX_WAIT   = 4'd8;
  localparam logic [3:0] S_ADX_STEP  = 4'd9;
  localparam logic [3:0] S_ADIV_GO   = 4'd10;
  localparam logic [3:0] S_ADIV_WAIT = 4'd11;
  localparam logic [3:0] S_ADX_FIN   = 4'd12;
  localparam logic [3:0] S_RESULT    = 4'd13;

  logic [3:0] state, state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (!sts.active) state_next = S_RESULT;
        else if (sts.seed) state_next = S_UPD;
        else state_next = S_SDIV_GO;
      end
      S_SDIV_GO: begin
        cmd.sdiv_go = 1'b1;
        state_next  = S_SDIV_WAIT;
      end
      S_SDIV_WAIT: begin
        if (!sts.div_busy) state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = sts.form ? S_DI_GO : S_RESULT;
      end
      S_DI_GO: begin
        cmd.pct_di_go = 1'b1;
        state_next    = S_DI_WAIT;
      end
      S_DI_WAIT: begin
        if (!sts.pct_busy) begin
          cmd.di_take = 1'b1;
          state_next  = S_DX_GO;
        end
      end
      S_DX_GO: begin
        cmd.pct_dx_go = 1'b1;
        state_next    = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (!sts.pct_busy) state_next = S_ADX_STEP;
      end
      S_ADX_STEP: begin
        cmd.adx_step = 1'b1;
        state_next   = sts.need_div ? S_ADIV_GO : S_RESULT;
      end
      S_ADIV_GO: begin
        cmd.adiv_go = 1'b1;
        state_next  = S_ADIV_WAIT;
      end
      S_ADIV_WAIT: begin
        if (!sts.div_busy) state_next = S_ADX_FIN;
      end
      S_ADX_FIN: begin
        cmd.adx_fin = 1'b1;
        state_next  = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.result) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `DMI_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, !in_ready)
  `DMI_ASSERT_NOW(a_result_has_slot, cmd.result, !out_valid || out_ready)
  `DMI_ASSERT_NOW(a_no_accept_while_dividing, sts.div_busy || sts.pct_busy, !in_ready)

endmodule

// ===== src/directional_movement_index.sv =====
// Top level of the Wilder average directional index block.
// Instantiates dmi_ctrl and dmi_datapath; uses dmi_pkg.
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, bar_*, series_start    | in
//  out     | out_valid/out_ready, status..warmup_left   | out
//  cfg     | cfg_wr_en, cfg_wr_data (smoothing_period)  | in
//
// For one smoothing bar, the time from one accepted transaction to the next is set by
// the two passes of the bit-serial period divider and the two passes of the ratio unit
// (default widths DIV_W = 58, Q_W = 23). ADX seed bars other than the last skip the
// second divider pass; warm-up bars make fewer passes.
// rst is synchronous and restores period 14 and an empty series.
// A new transaction is taken while the previous result still waits on out_ready.
module directional_movement_index #(
  parameter int PRICE_BITS  = dmi_pkg::PRICE_BITS_DEF,
  parameter int FRAC_BITS   = dmi_pkg::FRAC_BITS_DEF,
  parameter int PERIOD_BITS = dmi_pkg::PERIOD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wr_en,
  input  logic [PERIOD_BITS-1:0]                 cfg_wr_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [PRICE_BITS-1:0]                  bar_high,
  input  logic [PRICE_BITS-1:0]                  bar_low,
  input  logic [PRICE_BITS-1:0]                  bar_close,
  input  logic                                   series_start,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [dmi_pkg::STATUS_W-1:0]           status,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] adx_value,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] plus_di,
  output logic [FRAC_BITS+dmi_pkg::INT_BITS-1:0] neg_di,
  output logic [dmi_pkg::BARS_W-1:0]             bars_seen,
  output logic [PERIOD_BITS:0]                   warmup_left
);
  import dmi_pkg::*;

  dmi_cmd_t cmd;
  dmi_sts_t sts;

  dmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmi_datapath #(
    .PRICE_BITS  (PRICE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .bar_high     (bar_high),
    .bar_low      (bar_low),
    .bar_close    (bar_close),
    .series_start (series_start),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .adx_value    (adx_value),
    .plus_di      (plus_di),
    .neg_di       (neg_di),
    .bars_seen    (bars_seen),
    .warmup_left  (warmup_left)
  );

endmodule

// ===== dv/tb_directional_movement_index.sv =====
// Testbench for directional_movement_index: random bar streams under several periods.
// Depends on dmi_pkg and the RTL; a scoreboard class predicts every report.
`timescale 1ns / 100ps

module tb_directional_movement_index;
  import dmi_pkg::*;

  localparam logic [63:0] HUNDRED_Q = 64'd100 << FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 6000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [22:0]         adx;
    logic [22:0]         pdi;
    logic [22:0]         mdi;
    logic [31:0]         bars;
    logic [10:0]         warm;
  } adx_report_t;

  // Predicts ADX reports from accepted bars and checks the block's reports
  class adx_tracker;
    logic [9:0]  period;
    logic [63:0] prev_high, prev_low, prev_close, bar_cnt;
    logic [63:0] pdm_sum, mdm_sum, tr_sum, dx_cnt, adx_acc;
    bit          bad_seen;
    int          errors, reports;
    adx_report_t expected_reports[$];

    function void clear_series();
      prev_high = 0; prev_low = 0; prev_close = 0; bar_cnt = 0;
      pdm_sum = 0; mdm_sum = 0; tr_sum = 0; dx_cnt = 0; adx_acc = 0;
      bad_seen = 0;
    endfunction

    function new();
      period = PERIOD_RESET;
      errors = 0;
      reports = 0;
      clear_series();
    endfunction

    // floor(num * 100.0 / den) in Q form, saturated, zero on empty divisor
    function logic [63:0] pct(logic [63:0] num, logic [63:0] den);
      logic [63:0] q, r;
      q = 0;
      r = 0;
      if (den == 0) return 0;
      if (num >= den) return HUNDRED_Q;
      for (int b = 31; b >= 0; b--) begin
        q = q << 1;
        r = r << 1;
        if (HUNDRED_Q[b]) r = r + num;
        while (r >= den) begin
          r = r - den;
          q = q + 1;
        end
      end
      return q;
    endfunction

    function void take_bar(logic [31:0] h32, logic [31:0] l32, logic [31:0] c32, bit restart);
      logic [63:0] h, l, c, p, n, pdi, mdi, pdm, mdm, diff, dx, a;
      longint up, down, tr, hpc, lpc;
      adx_report_t rep;
      h = h32; l = l32; c = c32; p = period;
      pdi = 0; mdi = 0;
      if (restart) clear_series();
      if (h == 0 || l == 0 || c == 0) bad_seen = 1;
      if (bar_cnt < 64'hFFFF_FFFF) bar_cnt = bar_cnt + 1;
      n = bar_cnt;
      if (p != 0 && n >= 2) begin
        up = longint'(h) - longint'(prev_high);
        down = longint'(prev_low) - longint'(l);
        tr = longint'(h) - longint'(l);
        hpc = longint'(h) - longint'(prev_close);
        lpc = longint'(l) - longint'(prev_close);
        if (hpc < 0) hpc = -hpc;
        if (lpc < 0) lpc = -lpc;
        pdm = (up > down && up > 0) ? up : 0;
        mdm = (down > up && down > 0) ? down : 0;
        if (hpc > tr) tr = hpc;
        if (lpc > tr) tr = lpc;
        // seed sums, then Wilder recurrence
        if (n <= p + 1) begin
          pdm_sum = pdm_sum + (pdm << FRAC_BITS_DEF);
          mdm_sum = mdm_sum + (mdm << FRAC_BITS_DEF);
          tr_sum = tr_sum + (64'(tr) << FRAC_BITS_DEF);
        end else begin
          pdm_sum = pdm_sum - pdm_sum / p + (pdm << FRAC_BITS_DEF);
          mdm_sum = mdm_sum - mdm_sum / p + (mdm << FRAC_BITS_DEF);
          tr_sum = tr_sum - tr_sum / p + (64'(tr) << FRAC_BITS_DEF);
        end
        // DI, DX and the ADX seed average or smoothing
        if (n >= p + 1) begin
          pdi = pct(pdm_sum, tr_sum);
          mdi = pct(mdm_sum, tr_sum);
          diff = (pdi > mdi) ? pdi - mdi : mdi - pdi;
          dx = pct(diff, pdi + mdi);
          if (dx_cnt < p) begin
            adx_acc = (adx_acc + dx) & 64'h3_FFFF_FFFF;
            dx_cnt = (dx_cnt + 1) & 64'd2047;
            if (dx_cnt == p) adx_acc = adx_acc / p;
          end else begin
            adx_acc = ((adx_acc * (p - 1) + dx) / p) & 64'h3_FFFF_FFFF;
          end
        end
      end
      prev_high = h; prev_low = l; prev_close = c;
      rep = '{status: STATUS_OK, adx: 0, pdi: 0, mdi: 0, bars: 0, warm: 0};
      if (p == 0) begin
        rep.status = STATUS_INVALID;
      end else if (n < 2 * p + 1) begin
        rep.status = STATUS_SHORT;
        rep.bars = n[31:0];
        rep.warm = 11'(2 * p + 1 - n);
      end else if (bad_seen) begin
        rep.status = STATUS_INVALID;
      end else begin
        a = (adx_acc > HUNDRED_Q) ? HUNDRED_Q : adx_acc;
        rep.adx = a[22:0];
        rep.pdi = pdi[22:0];
        rep.mdi = mdi[22:0];
        rep.bars = n[31:0];
      end
      expected_reports = {expected_reports, rep};
    endfunction

    function void check_report(adx_report_t got);
      adx_report_t exp;
      if (expected_reports.size() == 0) begin
        $error("report with no transaction outstanding");
        errors++;
        return;
      end
      exp = expected_reports.pop_front();
      reports++;
      if (got.status !== exp.status) begin
        $error("status expected %0d actual %0d", exp.status, got.status); errors++;
      end
      if (got.adx !== exp.adx) begin
        $error("adx_value expected %0d actual %0d", exp.adx, got.adx); errors++;
      end
      if (got.pdi !== exp.pdi) begin
        $error("plus_di expected %0d actual %0d", exp.pdi, got.pdi); errors++;
      end
      if (got.mdi !== exp.mdi) begin
        $error("neg_di expected %0d actual %0d", exp.mdi, got.mdi); errors++;
      end
      if (got.bars !== exp.bars) begin
        $error("bars_seen expected %0d actual %0d", exp.bars, got.bars); errors++;
      end
      if (got.warm !== exp.warm) begin
        $error("warmup_left expected %0d actual %0d", exp.warm, got.warm); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_wr_en = 0;
  logic [9:0]  cfg_wr_data = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] bar_high = 0, bar_low = 0, bar_close = 0;
  logic        series_start = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [22:0] adx_value, plus_di, neg_di;
  logic [31:0] bars_seen;
  logic [10:0] warmup_left;

  adx_tracker tracker = new();
  int  idle_cycles = 0;
  int  bars_sent = 0;
  int  ready_hold = 0;
  bit  calm = 0;
  logic [31:0] walk = 32'd100000;

  always #6 clk = ~clk;

  directional_movement_index DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .bar_high(bar_high), .bar_low(bar_low),
    .bar_close(bar_close), .series_start(series_start), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .adx_value(adx_value), .plus_di(plus_di),
    .neg_di(neg_di), .bars_seen(bars_seen), .warmup_left(warmup_left)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Result side: random back-pressure, check each accepted report
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        tracker.check_report('{status, adx_value, plus_di, neg_di, bars_seen, warmup_left});
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!calm && $urandom_range(0, 9) < 3) ready_hold <= pick_gap();
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_bar(logic [31:0] h, logic [31:0] l, logic [31:0] c, bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    bar_high <= h;
    bar_low <= l;
    bar_close <= c;
    series_start <= restart;
    do @(posedge clk); while (!in_ready);
    tracker.take_bar(h, l, c, restart);
    bars_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (tracker.expected_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_period(logic [9:0] p);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 0;
    tracker.period = p;
  endtask

  // One random bar, mostly a price walk, sometimes odd shapes
  task automatic random_bar(bit restart);
    logic [31:0] h, l, c, t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      walk = $urandom;
    end
    h = walk + $urandom_range(0, 3000);
    l = walk - $urandom_range(0, 3000);
    c = l + $urandom_range(0, 6000);
    if (r >= 6 && r < 10) begin
      h = $urandom; l = $urandom; c = $urandom;
    end else if (r < 13) begin
      c = h + $urandom_range(1, 5000);
    end else if (r < 16) begin
      t = h; h = l; l = t;
    end else if (r < 18) begin
      case ($urandom_range(0, 2))
        0: h = 0;
        1: l = 0;
        default: c = 0;
      endcase
    end
    walk = c + $urandom_range(0, 4000) - 2000;
    if (walk < 32'd10000) walk = 32'd10000 + $urandom_range(0, 1000);
    send_bar(h, l, c, restart);
  endtask

  logic [9:0] periods[8] = '{10'd2, 10'd0, 10'd3, 10'd1023, 10'd7, 10'd14, 10'd5, 10'd1};

  initial begin
    int len;
    int phase_bars;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, zero prices, inverted bars, close outside range
    set_period(10'd1);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_bar(32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 0);
    send_bar(32'd1, 32'hFFFF_FFFF, 32'd1, 0);
    send_bar(32'd5000, 32'd4000, 32'd9000, 0);
    send_bar(32'd100, 32'd100, 32'd100, 0);
    send_bar(32'd100, 32'd100, 32'd100, 0);
    send_bar(32'd0, 32'd50, 32'd60, 0);
    send_bar(32'd200, 32'd150, 32'd170, 0);
    send_bar(32'd200, 32'd0, 32'd170, 1);
    send_bar(32'd200, 32'd150, 32'd0, 1);
    send_bar(32'd300, 32'd250, 32'd260, 0);
    send_bar(32'd310, 32'd240, 32'd255, 0);
    send_bar(32'd330, 32'd270, 32'd320, 1);
    send_bar(32'd340, 32'd280, 32'd330, 0);
    send_bar(32'd345, 32'd200, 32'd10, 0);
    send_bar(32'hFFFF_FFFE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
    set_period(10'd0);
    send_bar(32'd100, 32'd90, 32'd95, 1);
    send_bar(32'd0, 32'd0, 32'd0, 0);
    set_period(10'd1);
    send_bar(32'd120, 32'd100, 32'd110, 0);
    send_bar(32'd130, 32'd105, 32'd125, 0);

    // Random phases; the first series of a phase may keep the old state
    foreach (periods[i]) begin
      set_period(periods[i]);
      phase_bars = 0;
      while (phase_bars < ((periods[i] == 10'd1023) ? 40 : 85)) begin
        calm = ($urandom_range(0, 4) == 0);
        if (periods[i] == 10'd1023) len = 40;
        else len = 2 * periods[i] + 1 + $urandom_range(0, 20);
        for (int k = 0; k < len; k++)
          random_bar(k == 0 && !(phase_bars == 0 && $urandom_range(0, 1)));
        phase_bars += len;
      end
    end
    calm = 0;

    drain();
    repeat (300) @(posedge clk);
    $display("Sent %0d bars over periods 0, 1, 2, 3, 5, 7, 14 and 1023; %0d reports checked.",
             bars_sent, tracker.reports);
    if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
